FILE: rtl/dfd_pkg.sv
// shared types, constants and frame-check helpers for the display frame deframer
package dfd_pkg;

    // frame geometry
    localparam int unsigned FRAME_LEN  = 60;
    localparam int unsigned OFF_W      = 6;
    localparam logic [5:0]  FRAME_LAST = 6'd59;
    localparam logic [5:0]  SCAN_END   = 6'd60;
    localparam logic [5:0]  SUM_FIRST  = 6'd8;
    localparam logic [5:0]  SUM_EVEN_LAST = 6'd56;
    localparam logic [5:0]  SUM_ODD_FIRST = 6'd9;
    localparam logic [5:0]  SUM_ODD_LAST  = 6'd57;
    localparam logic [5:0]  EVEN_SUM_OFF  = 6'd58;
    localparam logic [5:0]  ODD_SUM_OFF   = 6'd59;
    localparam logic [5:0]  PAYLOAD_BASE  = 6'd9;
    localparam logic [3:0]  SECT_LAST_POS = 4'd13;
    localparam logic [1:0]  SECT_ICONS    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EVEN_ERR = 2'd1;
    localparam logic [1:0] KIND_ODD_ERR  = 2'd2;

    typedef logic [OFF_W-1:0] dfd_off_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } dfd_state_t;

    // request from the controller to the window memory
    typedef struct packed {
        logic     wr_en;
        dfd_off_t wr_off;
        logic     rd_en;
        dfd_off_t rd_off;
        logic     advance;
    } dfd_win_req_t;

    // expected byte at a checked offset
    typedef struct packed {
        logic       en;
        logic [7:0] val;
    } dfd_exp_t;

    function automatic dfd_exp_t expected_byte(input dfd_off_t off);
        dfd_exp_t e;
        e.en  = 1'b1;
        e.val = 8'h00;
        case (off)
            6'd0:    e.val = 8'h4d;
            6'd1:    e.val = 8'h50;
            6'd2:    e.val = 8'h53;
            6'd3:    e.val = 8'h45;
            6'd4:    e.val = 8'h4e;
            6'd5:    e.val = 8'h44;
            6'd8:    e.val = 8'hf0;
            6'd24:   e.val = 8'hf1;
            6'd40:   e.val = 8'hf2;
            6'd23:   e.val = 8'h00;
            6'd39:   e.val = 8'h00;
            6'd55:   e.val = 8'h00;
            default: e.en  = 1'b0;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/dfd_ifs.sv
// valid/ready channel interfaces for received bytes and deframed results
interface dfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] section;
    logic [3:0] position;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output section, output position,
                    output value, output last, input ready);
    modport sink   (input valid, input kind, input section, input position,
                    input value, input last, output ready);
endinterface

FILE: rtl/dfd_window.sv
// circular 60-byte window memory with a head pointer and a registered read
module dfd_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dfd_pkg::dfd_win_req_t req,
    input  logic [7:0]           wr_data,
    output logic [7:0]           rd_data
);

    logic [7:0]      mem [dfd_pkg::FRAME_LEN];
    dfd_pkg::dfd_off_t head_reg;
    dfd_pkg::dfd_off_t head_next;
    dfd_pkg::dfd_off_t wr_addr;
    dfd_pkg::dfd_off_t rd_addr;
    logic [7:0]      rd_data_reg;

    // head plus offset, wrapped into the 60 entries
    function automatic dfd_pkg::dfd_off_t wrap_addr(input dfd_pkg::dfd_off_t head,
                                                    input dfd_pkg::dfd_off_t off);
        logic [6:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= 7'(dfd_pkg::FRAME_LEN))
        begin
            sum = sum - 7'(dfd_pkg::FRAME_LEN);
        end
        return sum[5:0];
    endfunction

    assign wr_addr = wrap_addr(head_reg, req.wr_off);
    assign rd_addr = wrap_addr(head_reg, req.rd_off);

    // dropping the oldest byte moves the head by one
    always_comb
    begin
        head_next = head_reg;
        if (req.advance)
        begin
            head_next = (head_reg == dfd_pkg::FRAME_LAST) ? '0 : head_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    // storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/dfd_ctrl.sv
// sequencer: fills the window, scans it for header and checksums, emits results
module dfd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    dfd_in_if.sink                rx,
    dfd_out_if.source             result,
    output dfd_pkg::dfd_win_req_t win_req,
    input  logic [7:0]            rd_data
);

    dfd_pkg::dfd_state_t state_reg, state_next;
    dfd_pkg::dfd_off_t   fill_reg, fill_next;
    dfd_pkg::dfd_off_t   cnt_reg, cnt_next;
    logic                ok_reg, ok_next;
    logic [7:0]          ev_reg, ev_next;
    logic [7:0]          od_reg, od_next;
    logic [7:0]          b58_reg, b58_next;
    logic [7:0]          b59_reg, b59_next;
    logic [1:0]          sect_reg, sect_next;
    logic [3:0]          pos_reg, pos_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [1:0]          out_sect_reg, out_sect_next;
    logic [3:0]          out_pos_reg, out_pos_next;
    logic [7:0]          out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                out_free;
    logic                csum_bad;
    logic                emit_last;
    dfd_pkg::dfd_off_t   scan_off;
    dfd_pkg::dfd_exp_t   exp_byte;

    assign accept    = rx.valid && rx.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign csum_bad  = (ev_reg != b58_reg) || (od_reg != b59_reg);
    assign emit_last = (sect_reg == dfd_pkg::SECT_ICONS) && (pos_reg == dfd_pkg::SECT_LAST_POS);
    assign scan_off  = cnt_reg - 6'd1;
    assign exp_byte  = dfd_pkg::expected_byte(scan_off);

    assign rx.ready        = (state_reg == dfd_pkg::ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.kind     = out_kind_reg;
    assign result.section  = out_sect_reg;
    assign result.position = out_pos_reg;
    assign result.value    = out_value_reg;
    assign result.last     = out_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dfd_pkg::ST_IDLE:
            begin
                if (accept && fill_reg == dfd_pkg::FRAME_LAST)
                begin
                    state_next = dfd_pkg::ST_SCAN;
                end
            end
            dfd_pkg::ST_SCAN:
            begin
                if (cnt_reg == dfd_pkg::SCAN_END)
                begin
                    state_next = dfd_pkg::ST_DECIDE;
                end
            end
            dfd_pkg::ST_DECIDE:
            begin
                if (!ok_reg)
                begin
                    state_next = dfd_pkg::ST_IDLE;
                end
                else if (csum_bad)
                begin
                    if (out_free)
                    begin
                        state_next = dfd_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = dfd_pkg::ST_EMIT_RD;
                end
            end
            dfd_pkg::ST_EMIT_RD:
            begin
                state_next = dfd_pkg::ST_EMIT_LD;
            end
            dfd_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? dfd_pkg::ST_IDLE : dfd_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = dfd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath, window requests and result register
    always_comb
    begin
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        ok_next        = ok_reg;
        ev_next        = ev_reg;
        od_next        = od_reg;
        b58_next       = b58_reg;
        b59_next       = b59_reg;
        sect_next      = sect_reg;
        pos_next       = pos_reg;
        win_req        = '0;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_sect_next  = out_sect_reg;
        out_pos_next   = out_pos_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            dfd_pkg::ST_IDLE:
            begin
                // append the item at the tail of the window
                win_req.wr_off = fill_reg;
                if (accept)
                begin
                    win_req.wr_en = 1'b1;
                    fill_next     = fill_reg + 6'd1;
                    cnt_next      = '0;
                    ok_next       = 1'b1;
                    ev_next       = '0;
                    od_next       = '0;
                end
            end
            dfd_pkg::ST_SCAN:
            begin
                // read offset cnt, check the byte read in the cycle before
                win_req.rd_off = cnt_reg;
                win_req.rd_en  = (cnt_reg != dfd_pkg::SCAN_END);
                cnt_next       = cnt_reg + 6'd1;
                if (cnt_reg != '0)
                begin
                    if (exp_byte.en && rd_data != exp_byte.val)
                    begin
                        ok_next = 1'b0;
                    end
                    if (!scan_off[0] && scan_off >= dfd_pkg::SUM_FIRST &&
                        scan_off <= dfd_pkg::SUM_EVEN_LAST)
                    begin
                        ev_next = ev_reg ^ rd_data;
                    end
                    if (scan_off[0] && scan_off >= dfd_pkg::SUM_ODD_FIRST &&
                        scan_off <= dfd_pkg::SUM_ODD_LAST)
                    begin
                        od_next = od_reg ^ rd_data;
                    end
                    if (scan_off == dfd_pkg::EVEN_SUM_OFF)
                    begin
                        b58_next = rd_data;
                    end
                    if (scan_off == dfd_pkg::ODD_SUM_OFF)
                    begin
                        b59_next = rd_data;
                    end
                end
            end
            dfd_pkg::ST_DECIDE:
            begin
                if (!ok_reg)
                begin
                    // slide by one byte and wait for the next item
                    win_req.advance = 1'b1;
                    fill_next       = dfd_pkg::FRAME_LAST;
                end
                else if (csum_bad)
                begin
                    if (out_free)
                    begin
                        fill_next      = '0;
                        out_valid_next = 1'b1;
                        out_kind_next  = (ev_reg != b58_reg) ? dfd_pkg::KIND_EVEN_ERR
                                                             : dfd_pkg::KIND_ODD_ERR;
                        out_sect_next  = '0;
                        out_pos_next   = '0;
                        out_value_next = '0;
                        out_last_next  = 1'b1;
                    end
                end
                else
                begin
                    fill_next = '0;
                    sect_next = '0;
                    pos_next  = '0;
                end
            end
            dfd_pkg::ST_EMIT_RD:
            begin
                win_req.rd_en  = 1'b1;
                win_req.rd_off = dfd_pkg::PAYLOAD_BASE + {sect_reg, pos_reg};
            end
            dfd_pkg::ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = dfd_pkg::KIND_PAYLOAD;
                    out_sect_next  = sect_reg;
                    out_pos_next   = pos_reg;
                    out_value_next = rd_data;
                    out_last_next  = emit_last;
                    if (pos_reg == dfd_pkg::SECT_LAST_POS)
                    begin
                        pos_next  = '0;
                        sect_next = sect_reg + 2'd1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                win_req = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfd_pkg::ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ok_reg        <= ok_next;
        ev_reg        <= ev_next;
        od_reg        <= od_next;
        b58_reg       <= b58_next;
        b59_reg       <= b59_next;
        sect_reg      <= sect_next;
        pos_reg       <= pos_next;
        out_kind_reg  <= out_kind_next;
        out_sect_reg  <= out_sect_next;
        out_pos_reg   <= out_pos_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    // window never holds more than 59 bytes between items
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfd_pkg::ST_IDLE) |-> (fill_reg <= dfd_pkg::FRAME_LAST))
        else $error("fill count out of range");

    // the item that completes the window starts a scan
    a_full_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fill_reg == dfd_pkg::FRAME_LAST) |=> (state_reg == dfd_pkg::ST_SCAN))
        else $error("full window did not start a scan");

    // error results are always the final result of their item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != dfd_pkg::KIND_PAYLOAD) |-> out_last_reg)
        else $error("error result without last");

    // scan counter stays within the window plus one pipeline slot
    a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfd_pkg::ST_SCAN) |-> (cnt_reg <= dfd_pkg::SCAN_END))
        else $error("scan counter overran");

endmodule

FILE: rtl/display_frame_deframer.sv
// top level of the display frame deframer
// Received bytes go into a 60-byte circular window held in one synchronous
// memory. While the window is filling, one item is taken per cycle. The item
// that completes the window starts a scan that reads all 60 entries through
// the single read port, one per cycle, checking the "MPSEND" header, the
// F0/F1/F2 markers, the zero bytes and both XOR checksums; no item is taken
// while the scan runs. On a header, marker or zero-byte mismatch the head
// pointer moves by one byte and the next item is taken, so while hunting for
// sync each item starts a new scan. A good frame then emits its 42 payload
// bytes, each read from the window and then loaded into the result register,
// and a stall on the result side holds the emission; a checksum error emits
// a single result. Results leave from a register, so the last result of a
// frame can wait while new items are taken.
module display_frame_deframer (
    input  logic      clk,
    input  logic      rst_n,
    dfd_in_if.sink    rx,
    dfd_out_if.source result
);

    dfd_pkg::dfd_win_req_t win_req;
    logic [7:0]            rd_data;

    dfd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .result  (result),
        .win_req (win_req),
        .rd_data (rd_data)
    );

    dfd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (win_req),
        .wr_data (rx.rx_byte),
        .rd_data (rd_data)
    );

endmodule
